>>> hw/rtl/lts_pkg.sv
package lts_pkg;

    // Results one source beat can cause at most.
    localparam int MAX_RES = 3;
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    // Character codes the scanner keys on.
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_POINT      = 8'h2E;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    // Token kinds as they appear on the result channel.
    typedef enum logic [2:0] {
        KIND_END     = 3'd0,
        KIND_NEWLINE = 3'd1,
        KIND_BLANK   = 3'd2,
        KIND_COMMENT = 3'd3,
        KIND_IDENT   = 3'd4,
        KIND_NUMBER  = 3'd5,
        KIND_SYMBOL  = 3'd6,
        KIND_INVALID = 3'd7
    } kind_t;

    // Scanner modes: which token is open, or which byte is held for lookahead.
    typedef enum logic [3:0] {
        MODE_IDLE      = 4'd0,
        MODE_NEWLINE   = 4'd1,
        MODE_BLANK     = 4'd2,
        MODE_LINECOM   = 4'd3,
        MODE_BLOCK     = 4'd4,
        MODE_BLOCKSTAR = 4'd5,
        MODE_IDENT     = 4'd6,
        MODE_NUMBER    = 4'd7,
        MODE_SLASH     = 4'd8,
        MODE_POINT     = 4'd9
    } mode_t;

    function automatic logic is_newline(input logic [7:0] b);
        return (b == CH_LF) || (b == CH_CR);
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
    endfunction

    function automatic logic is_punct(input logic [7:0] b);
        return ((b >= 8'h21) && (b <= 8'h2F)) || ((b >= 8'h3A) && (b <= 8'h40)) ||
               ((b >= 8'h5B) && (b <= 8'h60)) || ((b >= 8'h7B) && (b <= 8'h7E));
    endfunction

endpackage

>>> hw/rtl/lts_scan_core.sv
module lts_scan_core #(
    parameter int LINE_BITS   = 20,
    parameter int COLUMN_BITS = 16,
    parameter int LENGTH_BITS = 16,
    localparam int REC_W      = 3 + 2 * LINE_BITS + 2 * COLUMN_BITS + LENGTH_BITS + 8 + 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [7:0]                    source_byte,
    input  logic                          end_of_text,
    output logic [REC_W-1:0]              res_data [lts_pkg::MAX_RES],
    output logic [lts_pkg::CNT_W-1:0]     res_count
);

    localparam int CW = REC_W - 1;

    localparam logic [7:0] CH_SLASH_B = lts_pkg::CH_SLASH;
    localparam logic [7:0] CH_POINT_B = lts_pkg::CH_POINT;

    // Scanner state.
    lts_pkg::mode_t           mode_reg, mode_next;
    logic [LINE_BITS-1:0]     line_reg, line_next;
    logic [COLUMN_BITS-1:0]   col_reg, col_next;
    logic [LINE_BITS-1:0]     open_line_reg, open_line_next;
    logic [COLUMN_BITS-1:0]   open_col_reg, open_col_next;
    logic [LENGTH_BITS-1:0]   open_len_reg, open_len_next;
    logic                     point_seen_reg, point_seen_next;
    logic [LINE_BITS-1:0]     held_line_reg, held_line_next;
    logic [COLUMN_BITS-1:0]   held_col_reg, held_col_next;

    // Candidate records in emission order: flushed token, held point, new byte or end.
    logic [CW-1:0]            cand [lts_pkg::MAX_RES];
    logic                     cand_v [lts_pkg::MAX_RES];

    logic [COLUMN_BITS-1:0]   pos_col;
    logic [COLUMN_BITS-1:0]   pos_col_after;
    logic [LENGTH_BITS-1:0]   len_plus1;
    logic [LENGTH_BITS-1:0]   len_plus2;
    logic                     do_start;

    function automatic logic [LINE_BITS-1:0] line_inc(input logic [LINE_BITS-1:0] v);
        logic [LINE_BITS:0] s;
        s = {1'b0, v} + (LINE_BITS + 1)'(1);
        return s[LINE_BITS] ? {LINE_BITS{1'b1}} : s[LINE_BITS-1:0];
    endfunction

    function automatic logic [COLUMN_BITS-1:0] col_inc(input logic [COLUMN_BITS-1:0] v);
        logic [COLUMN_BITS:0] s;
        s = {1'b0, v} + (COLUMN_BITS + 1)'(1);
        return s[COLUMN_BITS] ? {COLUMN_BITS{1'b1}} : s[COLUMN_BITS-1:0];
    endfunction

    function automatic logic [LENGTH_BITS-1:0] len_add(input logic [LENGTH_BITS-1:0] v,
                                                       input logic [1:0] k);
        logic [LENGTH_BITS:0] s;
        s = {1'b0, v} + (LENGTH_BITS + 1)'(k);
        return s[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : s[LENGTH_BITS-1:0];
    endfunction

    function automatic logic [CW-1:0] pack(input lts_pkg::kind_t k,
                                           input logic [LINE_BITS-1:0] sl,
                                           input logic [COLUMN_BITS-1:0] sc,
                                           input logic [LINE_BITS-1:0] el,
                                           input logic [COLUMN_BITS-1:0] ec,
                                           input logic [LENGTH_BITS-1:0] len,
                                           input logic [7:0] sym);
        return {k, sl, sc, el, ec, len, sym};
    endfunction

    assign pos_col       = col_inc(col_reg);
    assign pos_col_after = col_inc(pos_col);
    assign len_plus1     = len_add(open_len_reg, 2'd1);
    assign len_plus2     = len_add(open_len_reg, 2'd2);

    // Next state and candidate records for the beat in the input register.
    always_comb begin
        mode_next       = mode_reg;
        line_next       = line_reg;
        col_next        = col_reg;
        open_line_next  = open_line_reg;
        open_col_next   = open_col_reg;
        open_len_next   = open_len_reg;
        point_seen_next = point_seen_reg;
        held_line_next  = held_line_reg;
        held_col_next   = held_col_reg;
        do_start        = 1'b0;
        for (int i = 0; i < lts_pkg::MAX_RES; i++) begin
            cand[i]   = '0;
            cand_v[i] = 1'b0;
        end

        if (end_of_text) begin
            // Close whatever is open, then the end token at the end position.
            unique case (mode_reg)
                lts_pkg::MODE_NEWLINE: begin
                    cand[0]   = pack(lts_pkg::KIND_NEWLINE, open_line_reg, open_col_reg,
                                     line_reg, pos_col, open_len_reg, 8'h00);
                    cand_v[0] = 1'b1;
                end
                lts_pkg::MODE_BLANK: begin
                    cand[0]   = pack(lts_pkg::KIND_BLANK, open_line_reg, open_col_reg,
                                     line_reg, pos_col, open_len_reg, 8'h00);
                    cand_v[0] = 1'b1;
                end
                lts_pkg::MODE_LINECOM, lts_pkg::MODE_BLOCK, lts_pkg::MODE_BLOCKSTAR: begin
                    cand[0]   = pack(lts_pkg::KIND_COMMENT, open_line_reg, open_col_reg,
                                     line_reg, pos_col, open_len_reg, 8'h00);
                    cand_v[0] = 1'b1;
                end
                lts_pkg::MODE_IDENT: begin
                    cand[0]   = pack(lts_pkg::KIND_IDENT, open_line_reg, open_col_reg,
                                     line_reg, pos_col, open_len_reg, 8'h00);
                    cand_v[0] = 1'b1;
                end
                lts_pkg::MODE_NUMBER: begin
                    cand[0]   = pack(lts_pkg::KIND_NUMBER, open_line_reg, open_col_reg,
                                     line_reg, pos_col, open_len_reg, 8'h00);
                    cand_v[0] = 1'b1;
                end
                lts_pkg::MODE_SLASH: begin
                    cand[0]   = pack(lts_pkg::KIND_SYMBOL, held_line_reg, held_col_reg,
                                     held_line_reg, held_col_reg, LENGTH_BITS'(1), CH_SLASH_B);
                    cand_v[0] = 1'b1;
                end
                lts_pkg::MODE_POINT: begin
                    cand[0]   = pack(lts_pkg::KIND_NUMBER, open_line_reg, open_col_reg,
                                     held_line_reg, held_col_reg, open_len_reg, 8'h00);
                    cand_v[0] = 1'b1;
                    cand[1]   = pack(lts_pkg::KIND_SYMBOL, held_line_reg, held_col_reg,
                                     held_line_reg, held_col_reg, LENGTH_BITS'(1), CH_POINT_B);
                    cand_v[1] = 1'b1;
                end
                default: begin
                end
            endcase
            cand[2]   = pack(lts_pkg::KIND_END, line_reg, pos_col, line_reg, pos_col,
                             '0, 8'h00);
            cand_v[2] = 1'b1;

            // The text is over: back to the reset state.
            mode_next       = lts_pkg::MODE_IDLE;
            line_next       = LINE_BITS'(1);
            col_next        = '0;
            open_line_next  = LINE_BITS'(1);
            open_col_next   = '0;
            open_len_next   = '0;
            point_seen_next = 1'b0;
            held_line_next  = LINE_BITS'(1);
            held_col_next   = '0;
        end else begin
            // Position bookkeeping for the new byte.
            col_next = pos_col;
            if (lts_pkg::is_newline(source_byte)) begin
                line_next = line_inc(line_reg);
                col_next  = '0;
            end

            unique case (mode_reg)
                lts_pkg::MODE_NEWLINE: begin
                    if (lts_pkg::is_newline(source_byte)) begin
                        open_len_next = len_plus1;
                    end else begin
                        cand[0]   = pack(lts_pkg::KIND_NEWLINE, open_line_reg, open_col_reg,
                                         line_reg, pos_col, open_len_reg, 8'h00);
                        cand_v[0] = 1'b1;
                        do_start  = 1'b1;
                    end
                end
                lts_pkg::MODE_BLANK: begin
                    if (lts_pkg::is_blank(source_byte)) begin
                        open_len_next = len_plus1;
                    end else begin
                        cand[0]   = pack(lts_pkg::KIND_BLANK, open_line_reg, open_col_reg,
                                         line_reg, pos_col, open_len_reg, 8'h00);
                        cand_v[0] = 1'b1;
                        do_start  = 1'b1;
                    end
                end
                lts_pkg::MODE_LINECOM: begin
                    if (lts_pkg::is_newline(source_byte)) begin
                        cand[0]   = pack(lts_pkg::KIND_COMMENT, open_line_reg, open_col_reg,
                                         line_reg, pos_col, open_len_reg, 8'h00);
                        cand_v[0] = 1'b1;
                        do_start  = 1'b1;
                    end else begin
                        open_len_next = len_plus1;
                    end
                end
                lts_pkg::MODE_BLOCK: begin
                    open_len_next = len_plus1;
                    if (source_byte == lts_pkg::CH_STAR) begin
                        mode_next = lts_pkg::MODE_BLOCKSTAR;
                    end
                end
                lts_pkg::MODE_BLOCKSTAR: begin
                    open_len_next = len_plus1;
                    if (source_byte == lts_pkg::CH_SLASH) begin
                        // The closer ends the comment; its end is the next byte's place.
                        cand[0]   = pack(lts_pkg::KIND_COMMENT, open_line_reg, open_col_reg,
                                         line_reg, pos_col_after, len_plus1, 8'h00);
                        cand_v[0] = 1'b1;
                        mode_next = lts_pkg::MODE_IDLE;
                    end else if (source_byte != lts_pkg::CH_STAR) begin
                        mode_next = lts_pkg::MODE_BLOCK;
                    end
                end
                lts_pkg::MODE_IDENT: begin
                    if (lts_pkg::is_alpha(source_byte) || lts_pkg::is_digit(source_byte) ||
                        (source_byte == lts_pkg::CH_UNDERSCORE)) begin
                        open_len_next = len_plus1;
                    end else begin
                        cand[0]   = pack(lts_pkg::KIND_IDENT, open_line_reg, open_col_reg,
                                         line_reg, pos_col, open_len_reg, 8'h00);
                        cand_v[0] = 1'b1;
                        do_start  = 1'b1;
                    end
                end
                lts_pkg::MODE_NUMBER: begin
                    if (lts_pkg::is_digit(source_byte)) begin
                        open_len_next = len_plus1;
                    end else if ((source_byte == lts_pkg::CH_POINT) && !point_seen_reg) begin
                        mode_next      = lts_pkg::MODE_POINT;
                        held_line_next = line_reg;
                        held_col_next  = pos_col;
                    end else begin
                        cand[0]   = pack(lts_pkg::KIND_NUMBER, open_line_reg, open_col_reg,
                                         line_reg, pos_col, open_len_reg, 8'h00);
                        cand_v[0] = 1'b1;
                        do_start  = 1'b1;
                    end
                end
                lts_pkg::MODE_POINT: begin
                    if (lts_pkg::is_digit(source_byte)) begin
                        open_len_next   = len_plus2;
                        point_seen_next = 1'b1;
                        mode_next       = lts_pkg::MODE_NUMBER;
                    end else begin
                        // The number stops before the point, which becomes a symbol.
                        cand[0]   = pack(lts_pkg::KIND_NUMBER, open_line_reg, open_col_reg,
                                         held_line_reg, held_col_reg, open_len_reg, 8'h00);
                        cand_v[0] = 1'b1;
                        cand[1]   = pack(lts_pkg::KIND_SYMBOL, held_line_reg, held_col_reg,
                                         held_line_reg, held_col_reg, LENGTH_BITS'(1),
                                         CH_POINT_B);
                        cand_v[1] = 1'b1;
                        do_start  = 1'b1;
                    end
                end
                lts_pkg::MODE_SLASH: begin
                    if (source_byte == lts_pkg::CH_SLASH) begin
                        mode_next      = lts_pkg::MODE_LINECOM;
                        open_line_next = held_line_reg;
                        open_col_next  = held_col_reg;
                        open_len_next  = LENGTH_BITS'(2);
                    end else if (source_byte == lts_pkg::CH_STAR) begin
                        mode_next      = lts_pkg::MODE_BLOCK;
                        open_line_next = held_line_reg;
                        open_col_next  = held_col_reg;
                        open_len_next  = LENGTH_BITS'(2);
                    end else begin
                        // A lone slash is a symbol at its own position.
                        cand[0]   = pack(lts_pkg::KIND_SYMBOL, held_line_reg, held_col_reg,
                                         held_line_reg, held_col_reg, LENGTH_BITS'(1),
                                         CH_SLASH_B);
                        cand_v[0] = 1'b1;
                        do_start  = 1'b1;
                    end
                end
                default: begin
                    do_start = 1'b1;
                end
            endcase

            // A byte no open token takes starts a new one or is a one-byte record.
            if (do_start) begin
                mode_next = lts_pkg::MODE_IDLE;
                if (lts_pkg::is_newline(source_byte)) begin
                    mode_next      = lts_pkg::MODE_NEWLINE;
                    open_line_next = line_reg;
                    open_col_next  = pos_col;
                    open_len_next  = LENGTH_BITS'(1);
                end else if (lts_pkg::is_blank(source_byte)) begin
                    mode_next      = lts_pkg::MODE_BLANK;
                    open_line_next = line_reg;
                    open_col_next  = pos_col;
                    open_len_next  = LENGTH_BITS'(1);
                end else if (source_byte == lts_pkg::CH_SLASH) begin
                    mode_next      = lts_pkg::MODE_SLASH;
                    held_line_next = line_reg;
                    held_col_next  = pos_col;
                end else if (lts_pkg::is_alpha(source_byte) ||
                             (source_byte == lts_pkg::CH_UNDERSCORE)) begin
                    mode_next      = lts_pkg::MODE_IDENT;
                    open_line_next = line_reg;
                    open_col_next  = pos_col;
                    open_len_next  = LENGTH_BITS'(1);
                end else if (lts_pkg::is_digit(source_byte)) begin
                    mode_next       = lts_pkg::MODE_NUMBER;
                    open_line_next  = line_reg;
                    open_col_next   = pos_col;
                    open_len_next   = LENGTH_BITS'(1);
                    point_seen_next = 1'b0;
                end else if (lts_pkg::is_punct(source_byte)) begin
                    cand[2]   = pack(lts_pkg::KIND_SYMBOL, line_reg, pos_col, line_reg,
                                     pos_col, LENGTH_BITS'(1), source_byte);
                    cand_v[2] = 1'b1;
                end else begin
                    cand[2]   = pack(lts_pkg::KIND_INVALID, line_reg, pos_col, line_reg,
                                     pos_col, LENGTH_BITS'(1), source_byte);
                    cand_v[2] = 1'b1;
                end
            end
        end
    end

    // Pack the valid candidates to the front and flag the final one.
    always_comb begin
        logic [lts_pkg::CNT_W-1:0] cnt;
        logic [CW-1:0]             slot [lts_pkg::MAX_RES];
        cnt = '0;
        for (int i = 0; i < lts_pkg::MAX_RES; i++) begin
            slot[i] = '0;
        end
        for (int i = 0; i < lts_pkg::MAX_RES; i++) begin
            if (cand_v[i]) begin
                slot[cnt[1:0]] = cand[i];
                cnt            = cnt + lts_pkg::CNT_W'(1);
            end
        end
        for (int j = 0; j < lts_pkg::MAX_RES; j++) begin
            res_data[j] = {slot[j], (lts_pkg::CNT_W'(j) == (cnt - lts_pkg::CNT_W'(1)))};
        end
        res_count = cnt;
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= lts_pkg::MODE_IDLE;
            line_reg       <= LINE_BITS'(1);
            col_reg        <= '0;
            open_line_reg  <= LINE_BITS'(1);
            open_col_reg   <= '0;
            open_len_reg   <= '0;
            point_seen_reg <= 1'b0;
            held_line_reg  <= LINE_BITS'(1);
            held_col_reg   <= '0;
        end else if (step) begin
            mode_reg       <= mode_next;
            line_reg       <= line_next;
            col_reg        <= col_next;
            open_line_reg  <= open_line_next;
            open_col_reg   <= open_col_next;
            open_len_reg   <= open_len_next;
            point_seen_reg <= point_seen_next;
            held_line_reg  <= held_line_next;
            held_col_reg   <= held_col_next;
        end
    end

endmodule

>>> hw/rtl/lts_out_buf.sv
module lts_out_buf #(
    parameter int DATA_W = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [DATA_W-1:0]             load_data [lts_pkg::MAX_RES],
    input  logic [lts_pkg::CNT_W-1:0]     load_count,
    input  logic                          load_en,
    output logic                          can_load,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [DATA_W-1:0]             out_data
);

    // Result slots; slot 0 is presented, the rest shift down as beats leave.
    logic [DATA_W-1:0]         slot_reg [lts_pkg::MAX_RES];
    logic [lts_pkg::CNT_W-1:0] cnt_reg;
    logic                      pop;

    assign out_valid = (cnt_reg != '0);
    assign out_data  = slot_reg[0];
    assign pop       = out_valid && out_ready;

    // A new set of results may enter once the buffer empties in this cycle.
    assign can_load = (cnt_reg == '0) || ((cnt_reg == lts_pkg::CNT_W'(1)) && out_ready);

    // Occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (load_en) begin
            cnt_reg <= load_count;
        end else if (pop) begin
            cnt_reg <= cnt_reg - lts_pkg::CNT_W'(1);
        end
    end

    // Slot contents.
    always_ff @(posedge aclk) begin
        if (load_en) begin
            for (int i = 0; i < lts_pkg::MAX_RES; i++) begin
                slot_reg[i] <= load_data[i];
            end
        end else if (pop) begin
            for (int i = 0; i < lts_pkg::MAX_RES - 1; i++) begin
                slot_reg[i] <= slot_reg[i + 1];
            end
        end
    end

endmodule

>>> hw/rtl/source_lexer_token_scanner.sv
// Channel  | Direction | Ports                                            | Beat
// ---------+-----------+--------------------------------------------------+--------------------
// source   | in        | s_valid, s_ready, s_source_byte, s_end_of_text   | one byte or end mark
// tokens   | out       | m_valid, m_ready, m_token_kind .. m_last_of_run  | one token record
//
// A source beat is registered, then scanned combinationally; its zero to three records
// appear on the token channel from the next cycle on, one per cycle while m_ready is high.
// Sustained rate is one source beat per cycle while m_ready is high and each beat
// yields at most one record; a beat with more holds the scanner until they drain.
// Reset (aresetn low at a clock edge) returns to line 1, column 0 with nothing held.
// m_ready low stalls results; one source beat is still taken while a result waits.
module source_lexer_token_scanner #(
    parameter int LINE_BITS   = 20,
    parameter int COLUMN_BITS = 16,
    parameter int LENGTH_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_source_byte,
    input  logic                   s_end_of_text,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_token_kind,
    output logic [LINE_BITS-1:0]   m_start_line,
    output logic [COLUMN_BITS-1:0] m_start_column,
    output logic [LINE_BITS-1:0]   m_end_line,
    output logic [COLUMN_BITS-1:0] m_end_column,
    output logic [LENGTH_BITS-1:0] m_token_length,
    output logic [7:0]             m_symbol_byte,
    output logic                   m_last_of_run
);

    localparam int REC_W = 3 + 2 * LINE_BITS + 2 * COLUMN_BITS + LENGTH_BITS + 8 + 1;

    logic                      in_valid_reg;
    logic [7:0]                in_byte_reg;
    logic                      in_eot_reg;
    logic                      step;
    logic                      can_load;
    logic [REC_W-1:0]          res_data [lts_pkg::MAX_RES];
    logic [lts_pkg::CNT_W-1:0] res_count;
    logic [REC_W-1:0]          out_rec;

    // The held beat is scanned when the result buffer can take its records.
    assign step    = in_valid_reg && can_load;
    assign s_ready = !in_valid_reg || step;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_source_byte;
            in_eot_reg  <= s_end_of_text;
        end
    end

    lts_scan_core #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .source_byte (in_byte_reg),
        .end_of_text (in_eot_reg),
        .res_data    (res_data),
        .res_count   (res_count)
    );

    lts_out_buf #(
        .DATA_W (REC_W)
    ) u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_data  (res_data),
        .load_count (res_count),
        .load_en    (step),
        .can_load   (can_load),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_data   (out_rec)
    );

    // Unpack the presented record.
    assign {m_token_kind, m_start_line, m_start_column, m_end_line, m_end_column,
            m_token_length, m_symbol_byte, m_last_of_run} = out_rec;

endmodule
